// ===== sv/nds_pkg.sv =====
package nds_pkg;

  // table geometry
  localparam int DEF_NOTE_SLOTS = 128;
  localparam int HALF_SLOTS     = 64;
  localparam int HALF_W         = 6;
  localparam int SCAN_W         = HALF_W + 1;

  // field widths
  localparam int ACT_W   = 2;
  localparam int KIND_W  = 2;
  localparam int PITCH_W = 17;
  localparam int VEL_W   = 16;
  localparam int DUR_W   = 16;
  localparam int FRAME_W = 12;
  localparam int FPB_W   = 13;
  localparam int SR_W    = 18;
  localparam int TIME_W  = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_FPB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SR  = 1'b1;

  localparam logic [FPB_W-1:0]   FPB_RESET = 13'd256;
  localparam logic [SR_W-1:0]    SR_RESET  = 18'd48000;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 12'd4095;

  // duration to samples: product, then divide by one thousand as a drop of three bits
  // and a multiply by the rounded-up reciprocal of 125, exact over the whole product
  localparam int PROD_W   = DUR_W + SR_W;
  localparam int PRE_SH   = 3;
  localparam int EIGHTH_W = PROD_W - PRE_SH;
  localparam int RECIP_W  = 32;
  localparam int RECIP_SH = 38;
  localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;
  localparam int RPROD_W  = EIGHTH_W + RECIP_W;
  localparam int QUOT_W   = RPROD_W - RECIP_SH;

  // input actions
  localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SCAN     = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ON    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OVR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_start;
    logic div_step;
    logic note_on;
    logic override;
    logic scan_init;
    logic scan_rd;
    logic scan_hit;
    logic scan_push;
    logic scan_next;
    logic scan_flush;
    logic clock_adv;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             in_range;
    logic             slot_active;
    logic             div_done;
    logic             scan_done;
    logic             scan_hit;
    logic             pend_valid;
    logic             out_free;
  } sts_t;

endpackage

// ===== sv/nds_ctrl.sv =====
module nds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  nds_pkg::sts_t sts_i,
  output nds_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISP     = 4'd1;
  localparam logic [3:0] ST_MUL      = 4'd2;
  localparam logic [3:0] ST_DIV      = 4'd3;
  localparam logic [3:0] ST_NOTE_ON  = 4'd4;
  localparam logic [3:0] ST_OVR      = 4'd5;
  localparam logic [3:0] ST_SCAN_RD  = 4'd6;
  localparam logic [3:0] ST_SCAN_EV  = 4'd7;
  localparam logic [3:0] ST_SCAN_END = 4'd8;

  logic [3:0] state_q, state_d;

  assign s_tready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (sts_i.act == nds_pkg::ACT_NOTE_ON && sts_i.in_range) begin
          state_d = ST_MUL;
        end else if (sts_i.act == nds_pkg::ACT_NOTE_OFF && sts_i.in_range
                     && sts_i.slot_active) begin
          state_d = ST_OVR;
        end else if (sts_i.act == nds_pkg::ACT_SCAN) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_NOTE_ON;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_NOTE_ON: begin
        if (sts_i.out_free) begin
          cmd_o.note_on = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_OVR: begin
        if (sts_i.out_free) begin
          cmd_o.override = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_done) begin
          state_d = ST_SCAN_END;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        // a hit waits only when an older hit is pending and the output is full
        if (sts_i.scan_hit) begin
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.scan_hit  = 1'b1;
            cmd_o.scan_push = sts_i.pend_valid;
            cmd_o.scan_next = 1'b1;
            state_d         = ST_SCAN_RD;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = ST_SCAN_RD;
        end
      end
      ST_SCAN_END: begin
        if (!sts_i.pend_valid) begin
          cmd_o.clock_adv = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.scan_flush = 1'b1;
          cmd_o.clock_adv  = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/nds_datapath.sv =====
module nds_datapath #(
  parameter int NOTE_SLOTS = nds_pkg::DEF_NOTE_SLOTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item fields
  input  logic [nds_pkg::ACT_W-1:0]           action_i,
  input  logic [nds_pkg::PITCH_W-1:0]         pitch_i,
  input  logic [nds_pkg::VEL_W-1:0]           velocity_i,
  input  logic [nds_pkg::DUR_W-1:0]           duration_i,
  input  logic [nds_pkg::FRAME_W-1:0]         frame_offset_i,
  input  logic                                scan_half_i,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [nds_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nds_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // control
  input  nds_pkg::cmd_t                       cmd_i,
  output nds_pkg::sts_t                       sts_o,
  // result register
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [nds_pkg::KIND_W-1:0]          out_kind_o,
  output logic [nds_pkg::PITCH_W-1:0]         out_pitch_o,
  output logic [nds_pkg::VEL_W-1:0]           out_vel_o,
  output logic [nds_pkg::FRAME_W-1:0]         out_frame_o,
  output logic                                out_last_o
);

  localparam int SLOT_W = $clog2(NOTE_SLOTS);

  // latched item
  logic [nds_pkg::ACT_W-1:0]   act_q;
  logic [nds_pkg::PITCH_W-1:0] pitch_q;
  logic [nds_pkg::VEL_W-1:0]   vel_q;
  logic [nds_pkg::DUR_W-1:0]   dur_q;
  logic [nds_pkg::FRAME_W-1:0] off_q;
  logic                        half_q;

  // configuration and time base
  logic [nds_pkg::FPB_W-1:0]  fpb_q;
  logic [nds_pkg::SR_W-1:0]   sr_q;
  logic [nds_pkg::TIME_W-1:0] clock_q;

  // slot table
  logic [NOTE_SLOTS-1:0]       active_q;
  logic [nds_pkg::TIME_W-1:0]  end_mem   [NOTE_SLOTS];
  logic [nds_pkg::PITCH_W-1:0] pitch_mem [NOTE_SLOTS];
  logic [nds_pkg::TIME_W-1:0]  rd_end_q;
  logic [nds_pkg::PITCH_W-1:0] rd_pitch_q;

  // duration divider
  logic [nds_pkg::PROD_W-1:0]  prod_q;
  logic [nds_pkg::RPROD_W-1:0] recip_prod;
  logic [nds_pkg::QUOT_W-1:0]  quot_q;
  logic                        div_done_q;

  // scan walk and pending hit
  logic [nds_pkg::SCAN_W-1:0]  scan_cnt_q;
  logic [nds_pkg::SCAN_W-1:0]  scan_abs;
  logic                        scan_in_tab;
  logic [SLOT_W-1:0]           scan_idx;
  logic [nds_pkg::TIME_W-1:0]  diff;
  logic                        hit;
  logic [nds_pkg::FRAME_W-1:0] hit_frame;
  logic                        pend_valid_q;
  logic [nds_pkg::PITCH_W-1:0] pend_pitch_q;
  logic [nds_pkg::FRAME_W-1:0] pend_frame_q;

  // slot decode
  logic [7:0]                 int_part;
  logic                       neg_small;
  logic                       in_range;
  logic [SLOT_W-1:0]          slot_idx;
  logic [nds_pkg::TIME_W-1:0] end_time;

  // result register
  logic                        out_valid_q;
  logic [nds_pkg::KIND_W-1:0]  out_kind_q;
  logic [nds_pkg::PITCH_W-1:0] out_pitch_q;
  logic [nds_pkg::VEL_W-1:0]   out_vel_q;
  logic [nds_pkg::FRAME_W-1:0] out_frame_q;
  logic                        out_last_q;
  logic                        out_free;
  logic                        push;

  // slot from pitch, truncated toward zero; small negatives land on slot zero
  assign neg_small = pitch_q[16] && (pitch_q[15:8] == 8'hFF) && (pitch_q[7:0] != 8'h00);
  assign int_part  = pitch_q[16] ? 8'h00 : pitch_q[15:8];
  assign in_range  = pitch_q[16] ? neg_small : ({1'b0, int_part} < 9'(NOTE_SLOTS));
  assign slot_idx  = int_part[SLOT_W-1:0];

  // end of note: clock plus offset plus duration in samples
  assign end_time = clock_q + nds_pkg::TIME_W'(off_q) + nds_pkg::TIME_W'(quot_q);

  // divide by one thousand: drop three bits, then multiply by the reciprocal of 125
  assign recip_prod = nds_pkg::RPROD_W'(prod_q[nds_pkg::PROD_W-1:nds_pkg::PRE_SH])
                    * nds_pkg::RPROD_W'(nds_pkg::RECIP_125);

  // scan position and expiry test
  assign scan_abs    = {half_q, scan_cnt_q[nds_pkg::HALF_W-1:0]};
  assign scan_in_tab = ({1'b0, scan_abs} < (nds_pkg::SCAN_W + 1)'(NOTE_SLOTS));
  assign scan_idx    = scan_abs[SLOT_W-1:0];
  assign diff        = rd_end_q - clock_q;
  assign hit         = active_q[scan_idx] && (diff < nds_pkg::TIME_W'(fpb_q));
  assign hit_frame   = (diff > nds_pkg::TIME_W'(nds_pkg::FRAME_MAX)) ? nds_pkg::FRAME_MAX
                                                                   : diff[nds_pkg::FRAME_W-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign push     = cmd_i.note_on || cmd_i.override || cmd_i.scan_push || cmd_i.scan_flush;

  // status
  assign sts_o.act         = act_q;
  assign sts_o.in_range    = in_range;
  assign sts_o.slot_active = active_q[slot_idx];
  assign sts_o.div_done    = div_done_q;
  assign sts_o.scan_done   = scan_cnt_q[nds_pkg::HALF_W] || !scan_in_tab;
  assign sts_o.scan_hit    = hit;
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.out_free    = out_free;

  // control state, configuration and time base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q        <= nds_pkg::FPB_RESET;
      sr_q         <= nds_pkg::SR_RESET;
      clock_q      <= '0;
      active_q     <= '0;
      div_done_q   <= 1'b0;
      scan_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          nds_pkg::CFG_FPB: fpb_q <= cfg_data_i[nds_pkg::FPB_W-1:0];
          nds_pkg::CFG_SR:  sr_q  <= cfg_data_i[nds_pkg::SR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clock_adv && half_q) begin
        clock_q <= clock_q + nds_pkg::TIME_W'(fpb_q);
      end
      if (cmd_i.note_on) begin
        active_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.override) begin
        active_q[slot_idx] <= 1'b0;
      end
      if (cmd_i.scan_hit) begin
        active_q[scan_idx] <= 1'b0;
      end
      if (cmd_i.mul_start) begin
        div_done_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        div_done_q <= 1'b1;
      end
      if (cmd_i.scan_init) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_next) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (cmd_i.scan_hit) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.scan_flush || cmd_i.scan_init) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item latch, divider and pending hit payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q   <= action_i;
      pitch_q <= pitch_i;
      vel_q   <= velocity_i;
      dur_q   <= duration_i;
      off_q   <= frame_offset_i;
      half_q  <= scan_half_i;
    end
    if (cmd_i.mul_start) begin
      prod_q <= nds_pkg::PROD_W'(dur_q) * nds_pkg::PROD_W'(sr_q);
    end
    if (cmd_i.div_step) begin
      quot_q <= recip_prod[nds_pkg::RPROD_W-1:nds_pkg::RECIP_SH];
    end
    if (cmd_i.scan_hit) begin
      pend_pitch_q <= rd_pitch_q;
      pend_frame_q <= hit_frame;
    end
  end

  // slot memories, written by note-on, read by the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.note_on) begin
      end_mem[slot_idx]   <= end_time;
      pitch_mem[slot_idx] <= pitch_q;
    end
    if (cmd_i.scan_rd) begin
      rd_end_q   <= end_mem[scan_idx];
      rd_pitch_q <= pitch_mem[scan_idx];
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.note_on) begin
      out_kind_q  <= nds_pkg::KIND_ON;
      out_pitch_q <= pitch_q;
      out_vel_q   <= vel_q;
      out_frame_q <= off_q;
      out_last_q  <= 1'b1;
    end else if (cmd_i.override) begin
      out_kind_q  <= nds_pkg::KIND_OVR;
      out_pitch_q <= pitch_q;
      out_vel_q   <= '0;
      out_frame_q <= off_q;
      out_last_q  <= 1'b1;
    end else if (cmd_i.scan_push || cmd_i.scan_flush) begin
      out_kind_q  <= nds_pkg::KIND_SCHED;
      out_pitch_q <= pend_pitch_q;
      out_vel_q   <= '0;
      out_frame_q <= pend_frame_q;
      out_last_q  <= cmd_i.scan_flush;
    end else begin
      out_kind_q  <= out_kind_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_pitch_o = out_pitch_q;
  assign out_vel_o   = out_vel_q;
  assign out_frame_o = out_frame_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== sv/note_duration_scheduler_top.sv =====
// Note scheduler with one voice slot per pitch and an automatic note-off after a
// duration given in milliseconds. Input items carry an action on s_axis_tuser: note-on
// arms the slot picked by the pitch's integer part and reports a note-on, note-off
// override disarms an active slot and reports it, and a block-end scan walks one half
// of the slot table, reporting a scheduled note-off for every slot whose end time falls
// in the current block (the upper half scan then advances the sample clock by
// frames_per_block). Items are handled one at a time. Between accepts a note-on passes
// through decode, one multiply of duration by sample rate, a multiply by the
// reciprocal of one thousand plus a state to see it done, and the commit; an override
// through decode and commit; an item with no effect through decode alone. A scan gives
// each slot a read state, for the registered read of the end-time and pitch memories,
// and an evaluate state, then a closing state. Note-ons, overrides and scans stall
// further while the output is not taken. Results leave through an output register, so
// the next item is accepted while the last result waits; m_axis_tlast marks the final
// result of an item, and items with no result produce nothing. The slot memories need
// no clearing pass after reset: active flags in flip-flops guard every read.
module note_duration_scheduler_top #(
  parameter int NOTE_SLOTS = nds_pkg::DEF_NOTE_SLOTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pitch_q8[16:0], velocity_q8[32:17], duration_ms[48:33], frame_offset[60:49],
  // scan_half[61], zero pad[63:62]
  input  logic [63:0]                    s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // note_pitch_q8[16:0], note_velocity_q8[32:17], event_frame[44:33], zero pad[47:45]
  output logic [47:0]                    m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nds_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  nds_pkg::cmd_t cmd;
  nds_pkg::sts_t sts;

  logic [nds_pkg::PITCH_W-1:0] out_pitch;
  logic [nds_pkg::VEL_W-1:0]   out_vel;
  logic [nds_pkg::FRAME_W-1:0] out_frame;

  nds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nds_datapath #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (s_axis_tuser),
    .pitch_i        (s_axis_tdata[16:0]),
    .velocity_i     (s_axis_tdata[32:17]),
    .duration_i     (s_axis_tdata[48:33]),
    .frame_offset_i (s_axis_tdata[60:49]),
    .scan_half_i    (s_axis_tdata[61]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_kind_o     (m_axis_tuser),
    .out_pitch_o    (out_pitch),
    .out_vel_o      (out_vel),
    .out_frame_o    (out_frame),
    .out_last_o     (m_axis_tlast)
  );

  // pack result fields
  assign m_axis_tdata = {3'b000, out_frame, out_vel, out_pitch};

  // a scan never leaves a pending hit behind when the next item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !sts.pend_valid)
    else $error("pending scan hit left over at item accept");

  // a result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.note_on || cmd.override || cmd.scan_push || cmd.scan_flush) |-> sts.out_free)
    else $error("result pushed into a full output register");

  // a note-on is committed only for an in-range slot after the divide has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.note_on |-> (sts.in_range && sts.div_done))
    else $error("note-on committed early or out of range");

  // no slot read past the end of the scanned half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> !sts.scan_done)
    else $error("scan read beyond its half");

endmodule

// ===== bench/nds_checker.sv =====
`timescale 1ns / 100ps

module nds_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // pitch_q8[16:0], velocity_q8[32:17], duration_ms[48:33], frame_offset[60:49],
  // scan_half[61], zero pad[63:62]
  input  logic [63:0]                    s_axis_tdata,
  // action[1:0]
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // note_pitch_q8[16:0], note_velocity_q8[32:17], event_frame[44:33], zero pad[47:45]
  input  logic [47:0]                    m_axis_tdata,
  // event_kind[1:0]
  input  logic [1:0]                     m_axis_tuser,
  input  logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_cnt_o,
  output int                             pending_o,
  output int                             events_o,
  output int                             sched_offs_o
);

  typedef struct packed {
    logic [nds_pkg::KIND_W-1:0]  kind;
    logic [nds_pkg::PITCH_W-1:0] pitch;
    logic [nds_pkg::VEL_W-1:0]   vel;
    logic [nds_pkg::FRAME_W-1:0] frame;
    logic                        last;
  } note_event_t;

  // shadow copy of the voice table, the sample clock and the registers
  logic                        slot_on    [nds_pkg::DEF_NOTE_SLOTS];
  logic [nds_pkg::TIME_W-1:0]  slot_end   [nds_pkg::DEF_NOTE_SLOTS];
  logic [nds_pkg::PITCH_W-1:0] slot_pit   [nds_pkg::DEF_NOTE_SLOTS];
  logic [nds_pkg::TIME_W-1:0]  sample_clock;
  logic [nds_pkg::FPB_W-1:0]   block_frames;
  logic [nds_pkg::SR_W-1:0]    rate_hz;

  note_event_t due_events[$];

  // integer part truncated toward zero, -1 when it names no slot
  function automatic int slot_for_pitch(input logic signed [nds_pkg::PITCH_W-1:0] p);
    int v;
    int whole;
    v = p;
    whole = (v < 0) ? -((-v) >>> 8) : (v >>> 8);
    if (whole < 0 || whole >= nds_pkg::DEF_NOTE_SLOTS) return -1;
    return whole;
  endfunction

  // work out the events one accepted item causes and update the shadow table
  task automatic schedule_events(input logic [nds_pkg::ACT_W-1:0] act,
                                 input logic [63:0] d);
    logic signed [nds_pkg::PITCH_W-1:0] pitch;
    logic [nds_pkg::VEL_W-1:0]          vel;
    logic [nds_pkg::DUR_W-1:0]          dur;
    logic [nds_pkg::FRAME_W-1:0]        offs;
    logic                               half;
    logic [63:0]                        prod;
    logic [nds_pkg::TIME_W-1:0]         diff;
    note_event_t                        ev;
    note_event_t                        held;
    logic                               have_held;
    int                                 slot;
    int                                 base;
    int                                 i;
    pitch = d[16:0];
    vel   = d[32:17];
    dur   = d[48:33];
    offs  = d[60:49];
    half  = d[61];
    slot  = slot_for_pitch(pitch);
    have_held = 1'b0;
    held = '0;
    ev = '0;
    if (act == nds_pkg::ACT_NOTE_ON) begin
      if (slot >= 0) begin
        prod = 64'(dur) * 64'(rate_hz);
        slot_on[slot]  = 1'b1;
        slot_end[slot] = sample_clock + 32'(offs) + 32'(prod / 64'd1000);
        slot_pit[slot] = pitch;
        ev.kind = nds_pkg::KIND_ON;
        ev.pitch = pitch;
        ev.vel = vel;
        ev.frame = offs;
        ev.last = 1'b1;
        due_events.push_back(ev);
      end
    end else if (act == nds_pkg::ACT_NOTE_OFF) begin
      if (slot >= 0 && slot_on[slot]) begin
        slot_on[slot] = 1'b0;
        ev.kind = nds_pkg::KIND_OVR;
        ev.pitch = pitch;
        ev.vel = '0;
        ev.frame = offs;
        ev.last = 1'b1;
        due_events.push_back(ev);
      end
    end else if (act == nds_pkg::ACT_SCAN) begin
      base = half ? nds_pkg::HALF_SLOTS : 0;
      for (i = base; i < base + nds_pkg::HALF_SLOTS && i < nds_pkg::DEF_NOTE_SLOTS; i++) begin
        if (slot_on[i]) begin
          diff = slot_end[i] - sample_clock;
          if (diff < 32'(block_frames)) begin
            // the previous hit is not the last one of this scan
            if (have_held) due_events.push_back(held);
            held.kind = nds_pkg::KIND_SCHED;
            held.pitch = slot_pit[i];
            held.vel = '0;
            held.frame = (diff > 32'(nds_pkg::FRAME_MAX)) ? nds_pkg::FRAME_MAX
                                                          : diff[nds_pkg::FRAME_W-1:0];
            held.last = 1'b0;
            have_held = 1'b1;
            slot_on[i] = 1'b0;
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        due_events.push_back(held);
      end
      if (half) sample_clock = sample_clock + 32'(block_frames);
    end
  endtask

  // compare results first: a result never belongs to the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    note_event_t got;
    note_event_t exp;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < nds_pkg::DEF_NOTE_SLOTS; i++) begin
        slot_on[i]  = 1'b0;
        slot_end[i] = '0;
        slot_pit[i] = '0;
      end
      sample_clock = '0;
      block_frames = nds_pkg::FPB_RESET;
      rate_hz      = nds_pkg::SR_RESET;
      due_events.delete();
      fail_cnt_o   = 0;
      events_o     = 0;
      sched_offs_o = 0;
    end else begin
      // result side
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind  = m_axis_tuser;
        got.pitch = m_axis_tdata[16:0];
        got.vel   = m_axis_tdata[32:17];
        got.frame = m_axis_tdata[44:33];
        got.last  = m_axis_tlast;
        events_o++;
        if (got.kind == nds_pkg::KIND_SCHED) sched_offs_o++;
        if (due_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d pitch %h vel %h",
                   $time, got.kind, got.pitch, got.vel, " frame %0d last %0d",
                   got.frame, got.last);
          fail_cnt_o++;
        end else begin
          exp = due_events.pop_front();
          if (got.kind !== exp.kind || got.pitch !== exp.pitch || got.vel !== exp.vel ||
              got.frame !== exp.frame || got.last !== exp.last) begin
            $display("%0t: mismatch, expected kind %0d pitch %h vel %h frame %0d last %0d",
                     $time, exp.kind, exp.pitch, exp.vel, exp.frame, exp.last);
            $display("%0t:           got kind %0d pitch %h vel %h frame %0d last %0d",
                     $time, got.kind, got.pitch, got.vel, got.frame, got.last);
            fail_cnt_o++;
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == nds_pkg::CFG_FPB) block_frames = cfg_data_i[nds_pkg::FPB_W-1:0];
        else if (cfg_idx_i == nds_pkg::CFG_SR) rate_hz = cfg_data_i[nds_pkg::SR_W-1:0];
      end
      // input side
      if (s_axis_tvalid && s_axis_tready) schedule_events(s_axis_tuser, s_axis_tdata);
    end
    pending_o = due_events.size();
  end

endmodule

// ===== bench/tb_note_duration_scheduler_top.sv =====
`timescale 1ns / 100ps

module tb_note_duration_scheduler_top;

  localparam logic [nds_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 64;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           s_tvalid   = 1'b0;
  logic                           s_tready;
  logic [63:0]                    s_tdata    = '0;
  logic [1:0]                     s_tuser    = '0;
  logic                           m_tvalid;
  logic                           m_tready   = 1'b1;
  logic [47:0]                    m_tdata;
  logic [1:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_we     = 1'b0;
  logic [nds_pkg::CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [nds_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  int fail_cnt;
  int pending;
  int events_seen;
  int sched_offs;
  int items_taken;
  int quiet_cycles;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cur_fpb   = nds_pkg::FPB_RESET;
  int cur_sr    = nds_pkg::SR_RESET;
  int items_sent = 0;
  logic next_half = 1'b0;
  logic [nds_pkg::PITCH_W-1:0] armed_pitch[$];

  always #1 clk = ~clk;

  note_duration_scheduler_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  nds_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .events_o      (events_seen),
    .sched_offs_o  (sched_offs)
  );

  // count accepted items and cycles without any handshake
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      items_taken  <= 0;
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) items_taken <= items_taken + 1;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  always @(negedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= stall_pct);
  end

  // present one item and hold it until taken, with random gaps before it
  task automatic send_item(input logic [nds_pkg::ACT_W-1:0] act,
                           input logic [nds_pkg::PITCH_W-1:0] p,
                           input logic [nds_pkg::VEL_W-1:0] vel,
                           input logic [nds_pkg::DUR_W-1:0] dur,
                           input logic [nds_pkg::FRAME_W-1:0] offs, input logic half);
    int target;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata  = {2'b00, half, offs, dur, vel, p};
    s_tuser  = act;
    s_tvalid = 1'b1;
    target   = items_taken + 1;
    @(negedge clk);
    while (items_taken != target) @(negedge clk);
    items_sent++;
  endtask

  // let every expected result drain, then give an idle block time to finish
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [nds_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = nds_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == nds_pkg::CFG_FPB) cur_fpb = value;
    else cur_sr = value;
  endtask

  // mostly well-formed traffic: notes that expire within a few blocks, scans in pairs
  task automatic random_item();
    int pick;
    int span;
    logic [nds_pkg::ACT_W-1:0]   act;
    logic [nds_pkg::PITCH_W-1:0] p;
    logic [nds_pkg::DUR_W-1:0]   dur;
    logic [nds_pkg::FRAME_W-1:0] offs;
    logic                        half;
    pick = $urandom_range(0, 99);
    span = (cur_sr > 0) ? (cur_fpb * 4000) / cur_sr + 1 : 1;
    dur  = ($urandom_range(0, 9) == 0) ? nds_pkg::DUR_W'($urandom)
                                       : nds_pkg::DUR_W'($urandom_range(0, span));
    if (cur_fpb == 0 || $urandom_range(0, 9) == 0) offs = nds_pkg::FRAME_W'($urandom);
    else offs = nds_pkg::FRAME_W'($urandom_range(0, cur_fpb - 1));
    p    = nds_pkg::PITCH_W'(($urandom_range(0, 127) << 8) | $urandom_range(0, 255));
    half = $urandom_range(0, 1);
    if (pick < 45) begin
      act = nds_pkg::ACT_NOTE_ON;
      case ($urandom_range(0, 9))
        0: p = nds_pkg::PITCH_W'($urandom);
        1: p = nds_pkg::PITCH_W'(-$urandom_range(0, 255));
        default: ;
      endcase
      armed_pitch.push_back(p);
      if (armed_pitch.size() > 8) void'(armed_pitch.pop_front());
    end else if (pick < 62) begin
      act = nds_pkg::ACT_NOTE_OFF;
      if (armed_pitch.size() > 0 && $urandom_range(0, 9) < 7)
        p = armed_pitch[$urandom_range(0, armed_pitch.size() - 1)];
    end else if (pick < 96) begin
      act = nds_pkg::ACT_SCAN;
      if ($urandom_range(0, 9) != 0) half = next_half;
      next_half = ~half;
      p = nds_pkg::PITCH_W'($urandom);
    end else begin
      act = ACT_UNUSED;
      p = nds_pkg::PITCH_W'($urandom);
    end
    send_item(act, p, nds_pkg::VEL_W'($urandom), dur, offs, half);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: slot range edges, retrigger, idle override, unknown action, both halves
    send_item(nds_pkg::ACT_NOTE_ON,  17'h03C00, 16'hFFFF, 16'd0,    12'd0,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h00000, 16'h0000, 16'd1,    12'd4095, 1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h1FF01, 16'h00FF, 16'd0,    12'd5,    1'b1);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h1FFFF, 16'h1234, 16'd2,    12'd10,   1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h1FF00, 16'h5555, 16'd3,    12'd1,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h10000, 16'hAAAA, 16'd3,    12'd1,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h0FFFF, 16'h0001, 16'd3,    12'd1,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h08000, 16'h0002, 16'd3,    12'd1,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h07FFF, 16'h0100, 16'hFFFF, 12'd0,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h04000, 16'h8000, 16'd3,    12'd100,  1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h06480, 16'h7FFF, 16'd1,    12'd200,  1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h03F55, 16'h0F0F, 16'd4,    12'd0,    1'b0);
    send_item(nds_pkg::ACT_NOTE_OFF, 17'h07F00, 16'hFFFF, 16'hFFFF, 12'd4095, 1'b1);
    send_item(nds_pkg::ACT_NOTE_OFF, 17'h00500, 16'h1111, 16'd0,    12'd7,    1'b0);
    send_item(nds_pkg::ACT_NOTE_OFF, 17'h07F00, 16'h2222, 16'd0,    12'd8,    1'b0);
    send_item(nds_pkg::ACT_NOTE_OFF, 17'h03FFF, 16'h3333, 16'd0,    12'd9,    1'b0);
    send_item(nds_pkg::ACT_NOTE_ON,  17'h03F00, 16'h4444, 16'd0,    12'd0,    1'b0);
    send_item(ACT_UNUSED,            17'h1FFFF, 16'hFFFF, 16'hFFFF, 12'd4095, 1'b1);
    send_item(nds_pkg::ACT_SCAN,     17'h00000, 16'h0000, 16'd0,    12'd0,    1'b0);
    send_item(nds_pkg::ACT_SCAN,     17'h1FFFF, 16'hFFFF, 16'hFFFF, 12'd4095, 1'b1);
    send_item(nds_pkg::ACT_SCAN,     17'h00000, 16'h0000, 16'd0,    12'd0,    1'b0);
    send_item(nds_pkg::ACT_SCAN,     17'h00000, 16'h0000, 16'd0,    12'd0,    1'b1);

    // phase 0: reset settings, no idling
    repeat (ITEMS_PER_PHASE) random_item();

    // phases 1 to 4: new settings, each with its own idling pattern
    for (int ph = 1; ph <= 4; ph++) begin
      wait_quiet();
      case (ph)
        1: begin
          write_cfg(nds_pkg::CFG_FPB, 1);
          write_cfg(nds_pkg::CFG_SR, 8000);
          idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          write_cfg(nds_pkg::CFG_FPB, 4096);
          write_cfg(nds_pkg::CFG_SR, 192000);
          idle_pct = 0;
          stall_pct = 50;
        end
        3: begin
          // zero block length: scans expire nothing and the clock holds
          write_cfg(nds_pkg::CFG_FPB, 0);
          write_cfg(nds_pkg::CFG_SR, 44100);
          idle_pct = 18;
          stall_pct = 18;
        end
        default: begin
          write_cfg(nds_pkg::CFG_FPB, $urandom_range(2, 4095));
          write_cfg(nds_pkg::CFG_SR, $urandom_range(8000, 192000));
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) random_item();
    end

    wait_quiet();
    $display("sent %0d items over five register settings with mixed idling", items_sent);
    $display("checked %0d result items, %0d of them scheduled note-offs",
             events_seen, sched_offs);
    if (pending != 0)
      $display("%0t: %0d expected result items never arrived", $time, pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nds_pkg.sv
sv/nds_ctrl.sv
sv/nds_datapath.sv
sv/note_duration_scheduler_top.sv
bench/nds_checker.sv
bench/tb_note_duration_scheduler_top.sv
